// ===== rtl/adx_pkg.sv =====
// ----------------------------------------------------------------------------
// adx_pkg
// Shared constants for the average directional index core.
// ----------------------------------------------------------------------------
package adx_pkg;

  // smoothing factor register, unsigned Q1.16 with 1.0 = 2^16
  localparam int EMA_W = 17;
  localparam logic [EMA_W-1:0] EMA_RESET = 17'd8738;
  localparam logic [EMA_W-1:0] EMA_ONE = 17'h10000;

  // integer bits of a 0..100 value (100 < 2^7)
  localparam int INT_BITS = 7;

  // shift of the >> 16 after smoothing, which also sets its rounding constant
  localparam int EMA_FRAC = 16;

endpackage

// ===== rtl/adx_bar_if.sv =====
// ----------------------------------------------------------------------------
// adx_bar_if
// Price bar channel: valid/ready handshake with high, low, applied price
// and the revise flag.
// ----------------------------------------------------------------------------
interface adx_bar_if #(
  parameter int PRICE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] bar_high;
  logic [PRICE_BITS-1:0] bar_low;
  logic [PRICE_BITS-1:0] bar_applied;
  logic                  revise;

  modport source (output valid, bar_high, bar_low, bar_applied, revise, input ready);
  modport sink   (input valid, bar_high, bar_low, bar_applied, revise, output ready);
endinterface

// ===== rtl/adx_res_if.sv =====
// ----------------------------------------------------------------------------
// adx_res_if
// Result channel: valid/ready handshake with ADX, +DI and -DI in unsigned
// Q7.FRAC_BITS.
// ----------------------------------------------------------------------------
interface adx_res_if #(
  parameter int FRAC_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS+6:0] adx_value;
  logic [FRAC_BITS+6:0] plus_di;
  logic [FRAC_BITS+6:0] minus_di;

  modport source (output valid, adx_value, plus_di, minus_di, input ready);
  modport sink   (input valid, adx_value, plus_di, minus_di, output ready);
endinterface

// ===== rtl/average_directional_index_core.sv =====
// ----------------------------------------------------------------------------
// average_directional_index_core
// EMA-smoothed +DI, -DI and ADX per price bar, unsigned Q7.FRAC_BITS.
// ----------------------------------------------------------------------------
// One bar is in flight at a time. The first bar (and its revisions) returns
// zeros without running the jobs. Every later bar runs three jobs on a
// shared sequencer: +DI, -DI, then ADX. Each job uses the bit-serial divider
// (FRAC_BITS+7 quotient bits, one per cycle) unless the divisor is zero or
// the ratio saturates, then two passes through one multiplier for the EMA.
// A finished result sits in the output register, so the next bar is taken
// while it waits.
module average_directional_index_core #(
  parameter int PRICE_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  adx_bar_if.sink                   in_bar,
  adx_res_if.source                 out_res,
  input  logic                      cfg_we,
  input  logic [adx_pkg::EMA_W-1:0] cfg_data
);
  import adx_pkg::*;

  localparam int PW = PRICE_BITS;
  localparam int OW = FRAC_BITS + INT_BITS;
  localparam int DW = (PRICE_BITS > OW + 1) ? PRICE_BITS : OW + 1;
  localparam int MW = OW + EMA_W;
  localparam int SW = MW + 1;
  localparam logic [OW-1:0] FULL_SCALE = OW'(100) << FRAC_BITS;
  localparam logic [SW-1:0] ROUND_HALF = SW'(1) << (EMA_FRAC - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOVE  = 4'd1;
  localparam logic [3:0] S_RANGE = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL2  = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [1:0] JOB_PLUS  = 2'd0;
  localparam logic [1:0] JOB_MINUS = 2'd1;
  localparam logic [1:0] JOB_ADX   = 2'd2;

  // control
  logic [3:0]       state_r, state_nxt;
  logic [1:0]       bars_r, bars_nxt;
  logic [1:0]       job_r, job_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [EMA_W-1:0] ema_r;

  // bar state
  logic [PW-1:0] base_high_r, base_low_r, base_applied_r;
  logic [PW-1:0] cur_high_r, cur_low_r, cur_applied_r;
  logic [OW-1:0] base_plus_r, base_minus_r, base_adx_r;
  logic [OW-1:0] cur_plus_r, cur_minus_r, cur_adx_r;

  // datapath
  logic [PW-1:0] pdm_r, ndm_r, d_hl_r, d_ha_r, d_la_r, tr_r;
  logic [DW-1:0] num_r, den_r;
  logic [OW-1:0] tgt_r;
  logic [MW-1:0] acc_r, prod_r;
  logic [OW-1:0] out_adx_r, out_plus_r, out_minus_r;

  logic             in_acc, first_bar, out_load;
  logic             den_zero, num_ge, div_start, div_done;
  logic [OW-1:0]    div_quot;
  logic [EMA_W-1:0] a_eff, one_minus;
  logic [OW-1:0]    prev_sel, mul_a;
  logic [EMA_W-1:0] mul_b;
  logic [MW-1:0]    mul_p;
  logic [SW-1:0]    ema_sum;
  logic [OW-1:0]    smoothed;
  logic [OW:0]      pm_sum;
  logic [OW-1:0]    pm_spread;
  logic             tr_sel_hl, tr_sel_ha;

  assign in_bar.ready = (state_r == S_IDLE);
  assign in_acc       = in_bar.valid && in_bar.ready;
  // a revision before a second bar exists just replaces the first bar
  assign first_bar    = (bars_r == 2'd0) || (in_bar.revise && bars_r == 2'd1);
  assign out_load     = (state_r == S_OUT) && (!out_valid_r || out_res.ready);

  assign den_zero  = (den_r == '0);
  assign num_ge    = (num_r >= den_r);
  assign div_start = (state_r == S_CHK) && !den_zero && !num_ge;

  assign a_eff     = ema_r[EMA_W-1] ? EMA_ONE : ema_r;
  assign one_minus = EMA_ONE - a_eff;

  always_comb begin
    case (job_r)
      JOB_PLUS:  prev_sel = base_plus_r;
      JOB_MINUS: prev_sel = base_minus_r;
      default:   prev_sel = base_adx_r;
    endcase
  end

  // prev*(1-a) in the first pass, target*a in the second
  assign mul_a    = (state_r == S_MUL1) ? prev_sel : tgt_r;
  assign mul_b    = (state_r == S_MUL1) ? one_minus : a_eff;
  assign mul_p    = MW'(mul_a) * MW'(mul_b);
  assign ema_sum  = {1'b0, acc_r} + {1'b0, prod_r} + ROUND_HALF;
  assign smoothed = ema_sum[EMA_FRAC +: OW];

  assign pm_sum    = {1'b0, cur_plus_r} + {1'b0, cur_minus_r};
  assign pm_spread = (cur_plus_r >= cur_minus_r) ? cur_plus_r - cur_minus_r
                                                 : cur_minus_r - cur_plus_r;

  assign tr_sel_hl = (d_hl_r >= d_ha_r) && (d_hl_r >= d_la_r);
  assign tr_sel_ha = (d_ha_r >= d_la_r);

  adx_div #(
    .DW (DW),
    .QW (OW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    bars_nxt      = bars_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          bars_nxt  = first_bar ? 2'd1 : 2'd2;
          state_nxt = first_bar ? S_OUT : S_MOVE;
        end
      end
      S_MOVE:  state_nxt = S_RANGE;
      S_RANGE: begin
        job_nxt   = JOB_PLUS;
        state_nxt = S_PREP;
      end
      S_PREP:  state_nxt = S_CHK;
      S_CHK:   state_nxt = (den_zero || num_ge) ? S_MUL1 : S_DIV;
      S_DIV: begin
        if (div_done) state_nxt = S_MUL1;
      end
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_ACC;
      S_ACC: begin
        if (job_r == JOB_ADX) begin
          state_nxt = S_OUT;
        end else begin
          job_nxt   = job_r + 2'd1;
          state_nxt = S_PREP;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bars_r      <= 2'd0;
      job_r       <= JOB_PLUS;
      out_valid_r <= 1'b0;
      ema_r       <= EMA_RESET;
    end else begin
      state_r     <= state_nxt;
      bars_r      <= bars_nxt;
      job_r       <= job_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) ema_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!first_bar && !in_bar.revise) begin
            base_high_r    <= cur_high_r;
            base_low_r     <= cur_low_r;
            base_applied_r <= cur_applied_r;
            base_plus_r    <= cur_plus_r;
            base_minus_r   <= cur_minus_r;
            base_adx_r     <= cur_adx_r;
          end
          cur_high_r    <= in_bar.bar_high;
          cur_low_r     <= in_bar.bar_low;
          cur_applied_r <= in_bar.bar_applied;
          if (first_bar) begin
            cur_plus_r  <= '0;
            cur_minus_r <= '0;
            cur_adx_r   <= '0;
          end
        end
      end
      S_MOVE: begin
        pdm_r  <= (cur_high_r > base_high_r) ? cur_high_r - base_high_r : '0;
        ndm_r  <= (base_low_r > cur_low_r) ? base_low_r - cur_low_r : '0;
        d_hl_r <= (cur_high_r >= cur_low_r) ? cur_high_r - cur_low_r
                                            : cur_low_r - cur_high_r;
        d_ha_r <= (cur_high_r >= base_applied_r) ? cur_high_r - base_applied_r
                                                 : base_applied_r - cur_high_r;
        d_la_r <= (cur_low_r >= base_applied_r) ? cur_low_r - base_applied_r
                                                : base_applied_r - cur_low_r;
      end
      S_RANGE: begin
        // loser zeroed, both zeroed on a tie
        if (pdm_r == ndm_r) begin
          pdm_r <= '0;
          ndm_r <= '0;
        end else if (pdm_r < ndm_r) begin
          pdm_r <= '0;
        end else begin
          ndm_r <= '0;
        end
        tr_r <= tr_sel_hl ? d_hl_r : (tr_sel_ha ? d_ha_r : d_la_r);
      end
      S_PREP: begin
        case (job_r)
          JOB_PLUS: begin
            num_r <= DW'(pdm_r);
            den_r <= DW'(tr_r);
          end
          JOB_MINUS: begin
            num_r <= DW'(ndm_r);
            den_r <= DW'(tr_r);
          end
          default: begin
            num_r <= DW'(pm_spread);
            den_r <= DW'(pm_sum);
          end
        endcase
      end
      S_CHK: begin
        if (den_zero)    tgt_r <= '0;
        else if (num_ge) tgt_r <= FULL_SCALE;
      end
      S_DIV: begin
        if (div_done) tgt_r <= div_quot;
      end
      S_MUL1: acc_r  <= mul_p;
      S_MUL2: prod_r <= mul_p;
      S_ACC: begin
        case (job_r)
          JOB_PLUS:  cur_plus_r  <= smoothed;
          JOB_MINUS: cur_minus_r <= smoothed;
          default:   cur_adx_r   <= smoothed;
        endcase
      end
      S_OUT: begin
        if (out_load) begin
          out_adx_r   <= cur_adx_r;
          out_plus_r  <= cur_plus_r;
          out_minus_r <= cur_minus_r;
        end
      end
      default: ;
    endcase
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.adx_value = out_adx_r;
  assign out_res.plus_di   = out_plus_r;
  assign out_res.minus_di  = out_minus_r;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_bar.ready)
    else $error("new bar taken while previous one is still in work");

  a_bars_range: assert property (@(posedge clk) disable iff (!rst_n)
    bars_r != 2'd3)
    else $error("bar count out of range");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_adx_r <= FULL_SCALE) && (out_plus_r <= FULL_SCALE)
                    && (out_minus_r <= FULL_SCALE))
    else $error("result above full scale");

endmodule

// ===== rtl/adx_div.sv =====
// ----------------------------------------------------------------------------
// adx_div
// Iterative restoring divider for floor(num * 100 * 2^FRAC / den), one
// quotient bit per cycle. Caller guarantees den != 0 and num < den.
// ----------------------------------------------------------------------------
module adx_div #(
  parameter int DW = 32,
  parameter int QW = 23
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quot
);
  import adx_pkg::*;

  localparam int CW = $clog2(QW + 1);
  localparam int XW = DW + INT_BITS;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] xlo_r;
  logic [QW-1:0] quot_r;

  logic [XW-1:0] x100;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // num * 100 = num*64 + num*32 + num*4
  assign x100 = (XW'(num) << 6) + (XW'(num) << 5) + (XW'(num) << 2);

  assign shifted = {rem_r, xlo_r[QW-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // num < den, so the integer part of num*100 / 128 is already below den
      rem_r  <= x100[XW-1:INT_BITS];
      xlo_r  <= {x100[INT_BITS-1:0], {(QW-INT_BITS){1'b0}}};
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      xlo_r  <= {xlo_r[QW-2:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule
